### hw/rtl/plb_pkg.sv
// Shared types and constants for the positional list buffer.
// Used by the cell, the core and the port checker; depends on nothing else.
package plb_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Fixed widths of the external fields. Index and count hold up to 127.
  localparam int unsigned CntW = 7;
  localparam int unsigned IdxW = 7;
  localparam int unsigned PosW = 8;
  localparam int unsigned ValW = 32;
  localparam int unsigned OpW  = 3;
  localparam int unsigned StW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [IdxW-1:0] idx;
  } cell_ctrl_t;

endpackage

### hw/rtl/plb_cell.sv
// One storage cell of the list chain: holds a single word and shifts it
// toward or away from its neighbors. Depends on plb_pkg.
module plb_cell #(
  parameter int unsigned WORD_BITS = plb_pkg::WORD_BITS_DEF,
  parameter int unsigned INDEX     = 0
) (
  input  logic                   clk_i,
  input  plb_pkg::cell_ctrl_t    ctrl_i,
  input  logic [WORD_BITS-1:0]   left_i,
  input  logic [WORD_BITS-1:0]   right_i,
  input  logic [WORD_BITS-1:0]   new_word_i,
  output logic [WORD_BITS-1:0]   word_o,
  output logic [WORD_BITS-1:0]   hit_word_o
);

  localparam logic [plb_pkg::IdxW-1:0] MyIdx = plb_pkg::IdxW'(INDEX);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 at_idx, past_idx;

  assign at_idx   = (ctrl_i.idx == MyIdx);
  assign past_idx = (MyIdx > ctrl_i.idx);

  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (past_idx) begin
        word_d = left_i;
      end else if (at_idx) begin
        word_d = new_word_i;
      end
    end else if (ctrl_i.rem) begin
      if (past_idx || at_idx) begin
        word_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  assign hit_word_o = at_idx ? word_q : '0;

endmodule

### hw/rtl/positional_list_buffer_core.sv
// Top level of the positional list buffer: a chain of plb_cell registers
// with the index decode, size counter and result register. Depends on plb_pkg.
//
//   channel | handshake               | payload
//   in      | in_valid_i / in_ready_o  | opcode_i, position_i, value_i
//   out     | out_valid_o/ out_ready_i | removed_value_o, size_after_o, status_o
//
// All cells shift or hold together from one broadcast index compare, and
// the result lands in an output register the cycle after the beat. A new
// beat is taken whenever that register is empty or being drained, so one
// item per cycle is sustained while the output keeps draining.
// Reset clears the size counter and the output valid; cell words are not reset.
// A stalled output holds the result and blocks further input beats.
module positional_list_buffer_core #(
  parameter int unsigned CAPACITY  = plb_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = plb_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [plb_pkg::OpW-1:0]     opcode_i,
  input  logic signed [plb_pkg::PosW-1:0] position_i,
  input  logic [plb_pkg::ValW-1:0]    value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [plb_pkg::ValW-1:0]    removed_value_o,
  output logic [plb_pkg::CntW-1:0]    size_after_o,
  output logic [plb_pkg::StW-1:0]     status_o
);

  localparam int unsigned KeepW = (WORD_BITS < plb_pkg::ValW) ? WORD_BITS : plb_pkg::ValW;
  localparam logic [plb_pkg::CntW-1:0] CapCnt = plb_pkg::CntW'(CAPACITY);

  logic                          accept;
  logic                          out_valid_q;
  logic [plb_pkg::ValW-1:0]      removed_q, removed_d;
  logic [plb_pkg::CntW-1:0]      size_q;
  logic [plb_pkg::StW-1:0]       status_q;
  logic [plb_pkg::CntW-1:0]      count_q, count_d;
  plb_pkg::status_e              st;
  logic                          want_ins, want_rem;
  logic [plb_pkg::IdxW-1:0]      idx;
  logic [plb_pkg::IdxW-1:0]      pos_u;
  logic [plb_pkg::CntW-1:0]      last_idx;
  plb_pkg::cell_ctrl_t           ctrl;
  logic [WORD_BITS-1:0]          new_word;
  logic [WORD_BITS-1:0]          hit_or;
  logic [WORD_BITS-1:0]          cell_word [CAPACITY];
  logic [WORD_BITS-1:0]          cell_hit  [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_u      = position_i[plb_pkg::IdxW-1:0];
  assign last_idx   = count_q - plb_pkg::CntW'(1);
  assign new_word   = WORD_BITS'(value_i[KeepW-1:0]);

  // Index decode and status for the current operation.
  always_comb begin
    want_ins = 1'b0;
    want_rem = 1'b0;
    idx      = '0;
    st       = plb_pkg::ST_OK;
    case (plb_pkg::op_e'(opcode_i))
      plb_pkg::OP_INS_FRONT: begin
        want_ins = 1'b1;
      end
      plb_pkg::OP_INS_BACK: begin
        want_ins = 1'b1;
        idx      = count_q;
      end
      plb_pkg::OP_INS_AT: begin
        want_ins = 1'b1;
        if (position_i[plb_pkg::PosW-1]) begin
          idx = '0;
        end else if (pos_u > count_q) begin
          idx = count_q;
        end else begin
          idx = pos_u;
        end
      end
      plb_pkg::OP_REM_FRONT: begin
        want_rem = 1'b1;
      end
      plb_pkg::OP_REM_BACK: begin
        want_rem = 1'b1;
        idx      = last_idx;
      end
      plb_pkg::OP_REM_AT: begin
        if (position_i[plb_pkg::PosW-1]) begin
          st = plb_pkg::ST_EMPTY;
        end else begin
          want_rem = 1'b1;
          idx      = (pos_u >= count_q) ? last_idx : pos_u;
        end
      end
      default: begin
      end
    endcase

    if (want_ins && (count_q >= CapCnt)) begin
      want_ins = 1'b0;
      st       = plb_pkg::ST_FULL;
    end
    if (want_rem && (count_q == '0)) begin
      want_rem = 1'b0;
      st       = plb_pkg::ST_EMPTY;
    end
  end

  assign ctrl.ins = accept && want_ins;
  assign ctrl.rem = accept && want_rem;
  assign ctrl.idx = idx;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    plb_cell #(
      .WORD_BITS (WORD_BITS),
      .INDEX     (g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .left_i     (left_w),
      .right_i    (right_w),
      .new_word_i (new_word),
      .word_o     (cell_word[g]),
      .hit_word_o (cell_hit[g])
    );
  end

  // Only the addressed cell drives a nonzero hit word.
  always_comb begin
    hit_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_or = hit_or | cell_hit[i];
    end
  end

  always_comb begin
    removed_d = '0;
    count_d   = count_q;
    if (want_rem) begin
      removed_d = plb_pkg::ValW'(hit_or[KeepW-1:0]);
      count_d   = count_q - plb_pkg::CntW'(1);
    end else if (want_ins) begin
      count_d   = count_q + plb_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      size_q    <= count_d;
      status_q  <= st;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign size_after_o    = size_q;
  assign status_o        = status_q;

endmodule

### hw/rtl/plb_checker.sv
// Port-level checks for positional_list_buffer_core, attached by bind.
// Depends on plb_pkg.
module plb_checker #(
  parameter int unsigned CAPACITY = plb_pkg::CAPACITY_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [plb_pkg::ValW-1:0] removed_value_o,
  input logic [plb_pkg::CntW-1:0] size_after_o,
  input logic [plb_pkg::StW-1:0]  status_o
);

  localparam logic [plb_pkg::CntW-1:0] CapCnt = plb_pkg::CntW'(CAPACITY);

  // Every accepted input beat yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted input beat");

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(removed_value_o)
      && $stable(size_after_o) && $stable(status_o))
    else $error("stalled result changed");

  // A dropped insert can only happen on a full list.
  a_full_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == plb_pkg::ST_FULL |-> size_after_o == CapCnt)
    else $error("insert dropped while list not full");

  // A failed remove returns a zero word, and size never exceeds capacity.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> size_after_o <= CapCnt
      && (status_o != plb_pkg::ST_EMPTY || removed_value_o == '0))
    else $error("bad size or nonzero word on failed remove");

endmodule

bind positional_list_buffer_core plb_checker #(
  .CAPACITY (CAPACITY)
) u_plb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .removed_value_o (removed_value_o),
  .size_after_o    (size_after_o),
  .status_o        (status_o)
);

### test/plb_list_checker.sv
// Port checker for the positional list buffer: keeps its own copy of the list,
// predicts one result per input beat and compares it with each output beat.
// Depends on plb_pkg for the operation and status codes.
module plb_list_checker #(
  parameter int unsigned CAPACITY = plb_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [plb_pkg::OpW-1:0]         opcode_i,
  input  logic signed [plb_pkg::PosW-1:0] position_i,
  input  logic [plb_pkg::ValW-1:0]        value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [plb_pkg::ValW-1:0]        removed_value_i,
  input  logic [plb_pkg::CntW-1:0]        size_after_i,
  input  logic [plb_pkg::StW-1:0]         status_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct packed {
    logic [plb_pkg::ValW-1:0] word;
    logic [plb_pkg::CntW-1:0] size;
    logic [plb_pkg::StW-1:0]  status;
  } list_result_t;

  logic [plb_pkg::ValW-1:0] stored_words[$];
  list_result_t             expected_results[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Applies one operation to the list copy and returns the result it yields.
  function automatic list_result_t apply_list_op(
      input logic [plb_pkg::OpW-1:0]         op,
      input logic signed [plb_pkg::PosW-1:0] pos,
      input logic [plb_pkg::ValW-1:0]        val);
    list_result_t r;
    int           n;
    int           idx;
    r   = '0;
    n   = stored_words.size();
    idx = 0;
    case (op)
      plb_pkg::OP_INS_FRONT, plb_pkg::OP_INS_BACK, plb_pkg::OP_INS_AT: begin
        if (n >= CAPACITY) begin
          r.status = plb_pkg::ST_FULL;
        end else begin
          if (op == plb_pkg::OP_INS_BACK) idx = n;
          else if (op == plb_pkg::OP_INS_AT)
            idx = (pos <= 0) ? 0 : ((int'(pos) > n) ? n : int'(pos));
          stored_words.insert(idx, val);
        end
      end
      plb_pkg::OP_REM_FRONT, plb_pkg::OP_REM_BACK, plb_pkg::OP_REM_AT: begin
        // A negative remove position fails even on a non-empty list.
        if ((op == plb_pkg::OP_REM_AT && pos < 0) || n == 0) begin
          r.status = plb_pkg::ST_EMPTY;
        end else begin
          if (op == plb_pkg::OP_REM_BACK) idx = n - 1;
          else if (op == plb_pkg::OP_REM_AT) idx = (int'(pos) >= n) ? n - 1 : int'(pos);
          r.word = stored_words[idx];
          stored_words.delete(idx);
        end
      end
      default: ;
    endcase
    r.size = plb_pkg::CntW'(stored_words.size());
    return r;
  endfunction

  task automatic report_field(input string field, input logic [plb_pkg::ValW-1:0] exp_val,
                              input logic [plb_pkg::ValW-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, act_val);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  // Output beats are checked before the input beat of the same edge is added,
  // since a result always comes out of a register after its operation.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got word %0h size %0d status %0d",
                   $time, removed_value_i, size_after_i, status_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          report_field("removed_value", want.word, removed_value_i);
          report_field("size_after", plb_pkg::ValW'(want.size), plb_pkg::ValW'(size_after_i));
          report_field("status", plb_pkg::ValW'(want.status), plb_pkg::ValW'(status_i));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_list_op(opcode_i, position_i, value_i));
      pending_o = expected_results.size();
    end
  end

endmodule

### test/tb.sv
// Testbench top for positional_list_buffer_core: clock, reset, stimulus and verdict.
// Depends on plb_pkg, the core RTL and plb_list_checker, which does the prediction.
module tb;

  // Opcodes the block treats as no operation.
  localparam logic [plb_pkg::OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [plb_pkg::OpW-1:0] OpSpare7 = 3'd7;
  localparam int BlockLen  = 40;
  localparam int PhaseLen  = 430;

  logic                            clk_i     = 1'b0;
  logic                            rst_ni    = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic [plb_pkg::OpW-1:0]         opcode    = '0;
  logic signed [plb_pkg::PosW-1:0] position  = '0;
  logic [plb_pkg::ValW-1:0]        value     = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [plb_pkg::ValW-1:0]        removed_value;
  logic [plb_pkg::CntW-1:0]        size_after;
  logic [plb_pkg::StW-1:0]         status;
  int                              fail_count;
  int                              pending;
  int                              send_idle_pct = 20;
  int                              recv_stall_pct = 60;

  always #2 clk_i = ~clk_i;

  positional_list_buffer_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .position_i      (position),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .removed_value_o (removed_value),
    .size_after_o    (size_after),
    .status_o        (status)
  );

  plb_list_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .position_i      (position),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .removed_value_i (removed_value),
    .size_after_i    (size_after),
    .status_i        (status),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(negedge clk_i) begin
    if (rst_ni) out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_op(input logic [plb_pkg::OpW-1:0] op,
                         input logic signed [plb_pkg::PosW-1:0] pos,
                         input logic [plb_pkg::ValW-1:0] val);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    position <= pos;
    value    <= val;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // The insert share moves block by block so the list is driven to full,
  // held near full, drained past empty and held near empty.
  task automatic send_random_op(input int item_no);
    int                        ins_pct;
    int                        pick;
    logic [plb_pkg::OpW-1:0]   op;
    logic [plb_pkg::PosW-1:0]  pos;
    logic [plb_pkg::ValW-1:0]  val;
    case ((item_no / BlockLen) % 6)
      0, 1:    ins_pct = 90;
      3, 4:    ins_pct = 15;
      default: ins_pct = 50;
    endcase
    pick = $urandom_range(99, 0);
    if (pick < 3) op = ($urandom_range(1, 0) != 0) ? OpSpare6 : OpSpare7;
    else if (pick < 3 + ins_pct * 97 / 100) begin
      case ($urandom_range(3, 0))
        0:       op = plb_pkg::OP_INS_FRONT;
        1:       op = plb_pkg::OP_INS_BACK;
        default: op = plb_pkg::OP_INS_AT;
      endcase
    end else begin
      case ($urandom_range(3, 0))
        0:       op = plb_pkg::OP_REM_FRONT;
        1:       op = plb_pkg::OP_REM_BACK;
        default: op = plb_pkg::OP_REM_AT;
      endcase
    end
    pick = $urandom_range(99, 0);
    if (pick < 25) pos = plb_pkg::PosW'($urandom_range(255, 0));
    else if (pick < 70) pos = plb_pkg::PosW'($urandom_range(66, 0));
    else if (pick < 85) pos = plb_pkg::PosW'($urandom_range(3, 0));
    else pos = plb_pkg::PosW'($urandom_range(66, 60));
    pick = $urandom_range(9, 0);
    if (pick == 0) val = '0;
    else if (pick == 1) val = '1;
    else val = $urandom;
    send_op(op, pos, val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Removes on an empty list, a no-op, then the single-word case.
    send_op(plb_pkg::OP_REM_FRONT, 8'sd0, 32'h0);
    send_op(plb_pkg::OP_REM_BACK, 8'sd0, 32'h0);
    send_op(plb_pkg::OP_REM_AT, 8'sd0, 32'h0);
    send_op(plb_pkg::OP_REM_AT, -8'sd1, 32'h0);
    send_op(OpSpare6, 8'sd0, 32'h1);
    send_op(plb_pkg::OP_INS_AT, 8'sh80, 32'hFFFF_FFFF);
    send_op(plb_pkg::OP_REM_BACK, 8'sd0, 32'h0);
    // Build a short list through every insert kind and clamped positions.
    send_op(plb_pkg::OP_INS_BACK, 8'sd0, 32'h0);
    send_op(plb_pkg::OP_INS_FRONT, 8'sd0, 32'hAAAA_AAAA);
    send_op(plb_pkg::OP_INS_AT, 8'sd127, 32'h5555_5555);
    send_op(plb_pkg::OP_INS_AT, 8'sd1, 32'h1234_5678);
    send_op(plb_pkg::OP_INS_AT, 8'sd0, 32'h8000_0001);
    // Take it apart again, including a past-the-end and a negative remove.
    send_op(plb_pkg::OP_REM_AT, 8'sd127, 32'h0);
    send_op(plb_pkg::OP_REM_AT, 8'sh80, 32'h0);
    send_op(plb_pkg::OP_REM_AT, 8'sd1, 32'h0);
    send_op(OpSpare7, 8'sd3, 32'hFFFF_FFFF);
    send_op(plb_pkg::OP_REM_FRONT, 8'sd0, 32'h0);
    send_op(plb_pkg::OP_REM_AT, 8'sd0, 32'h0);
    send_op(plb_pkg::OP_REM_FRONT, 8'sd0, 32'h0);
    send_op(plb_pkg::OP_REM_AT, 8'sd127, 32'h0);

    for (int i = 0; i < PhaseLen; i++) send_random_op(i);
    wait_drained();

    send_idle_pct  = 60;
    recv_stall_pct = 20;
    for (int i = PhaseLen; i < 2 * PhaseLen; i++) send_random_op(i);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 2 * PhaseLen; i < 3 * PhaseLen + 10; i++) send_random_op(i);
    wait_drained();
    repeat (10) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/plb_pkg.sv
hw/rtl/plb_cell.sv
hw/rtl/positional_list_buffer_core.sv
hw/rtl/plb_checker.sv
test/plb_list_checker.sv
test/tb.sv
